// ===== rtl/sgt_pkg.sv =====
package sgt_pkg;

	localparam int MAX_BONES_DEF = 256;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int ROT_BITS = 28;
	localparam int WORDS = 12;
	localparam int SLOT_BITS = 4;
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 32;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int ACC_W = PROD_W + 2;

	typedef logic signed [31:0] word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	function automatic acc_t round_shift(input acc_t v, input int s);
		acc_t half;
		half = acc_t'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	function automatic word_t sat32(input acc_t v);
		word_t r;
		if (v > acc_t'(32'sh7fffffff))
			r = 32'sh7fffffff;
		else if (v < -acc_t'(33'sh080000000))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ===== rtl/sgt_mul.sv =====
module sgt_mul (
	input  logic                                 clk,
	input  logic signed [sgt_pkg::MUL_A_W-1:0]   a,
	input  logic signed [sgt_pkg::MUL_B_W-1:0]   b,
	output logic signed [sgt_pkg::PROD_W-1:0]    prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= sgt_pkg::PROD_W'(a) * sgt_pkg::PROD_W'(b);
	end

endmodule

// ===== rtl/sgt_ram.sv =====
module sgt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

endmodule

// ===== rtl/skeleton_global_transform_core.sv =====
// Forward kinematics for one pose, one bone per word in parent-first order.
// Each bone is taken as translation, Q2.14 quaternion, scale and parent
// position; the block returns the top three rows of its global matrix in
// Q(32-F).F and keeps them for later children. The block takes one word at a
// time: a single registered multiplier is stepped by a small sequencer. A root
// bone runs 9 quaternion products, 9 scaled rotation entries and 12 store
// writes; a bone with a valid parent also fetches its parent's 12 words and
// runs 36 more products before the writes.
// The last-bone flag restarts the bone position at zero.
module skeleton_global_transform_core #(
	parameter int MAX_BONES = sgt_pkg::MAX_BONES_DEF,
	parameter int FRACTION_BITS = sgt_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] translation_x,
	input  logic signed [31:0] translation_y,
	input  logic signed [31:0] translation_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	input  logic signed [8:0]  parent_bone,
	input  logic               last_bone,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] m_row0_col0,
	output logic signed [31:0] m_row0_col1,
	output logic signed [31:0] m_row0_col2,
	output logic signed [31:0] m_row0_col3,
	output logic signed [31:0] m_row1_col0,
	output logic signed [31:0] m_row1_col1,
	output logic signed [31:0] m_row1_col2,
	output logic signed [31:0] m_row1_col3,
	output logic signed [31:0] m_row2_col0,
	output logic signed [31:0] m_row2_col1,
	output logic signed [31:0] m_row2_col2,
	output logic signed [31:0] m_row2_col3
);

	localparam int BW = $clog2(MAX_BONES);
	localparam int CW = BW + 9;
	localparam int AW = BW + sgt_pkg::SLOT_BITS;
	localparam int DEPTH = MAX_BONES * (1 << sgt_pkg::SLOT_BITS);
	localparam int RSH = sgt_pkg::ROT_BITS - FRACTION_BITS;
	localparam int AWD = sgt_pkg::MUL_A_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_QUAT   = 3'd1;
	localparam logic [2:0] S_LOC    = 3'd2;
	localparam logic [2:0] S_PFETCH = 3'd3;
	localparam logic [2:0] S_GLOB   = 3'd4;
	localparam logic [2:0] S_WRITE  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0]    state_q;
	logic [3:0]    cnt_q;
	logic          ph_q;
	logic [1:0]    r_q, c_q, k_q;
	logic [BW-1:0] bone_q;
	logic          pv_q;
	logic          last_q;
	logic [BW-1:0] pidx_q;
	logic          rd_pend_q;
	logic [3:0]    rd_idx_q;

	sgt_pkg::word_t   s_q [3];
	logic signed [15:0] q_q [4];
	logic signed [31:0] qp_q [9];
	sgt_pkg::word_t   loc_q [3][4];
	sgt_pkg::word_t   p_q [3][4];
	sgt_pkg::word_t   m_q [3][4];
	sgt_pkg::acc_t    acc_q;

	logic signed [AWD-1:0]              mul_a;
	logic signed [sgt_pkg::MUL_B_W-1:0] mul_b;
	logic signed [sgt_pkg::PROD_W-1:0]  prod_q;
	logic signed [AWD-1:0] r28, rf;
	logic signed [AWD-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz, one;
	sgt_pkg::acc_t rp, sum, fin;
	logic          pv_in;
	logic [CW-1:0] par_ext;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   rdata_q;

	sgt_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	sgt_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (m_q[cnt_q[3:2]][cnt_q[1:0]]),
		.raddr   (raddr),
		.rdata_q (rdata_q)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign par_ext = CW'(parent_bone[7:0]);
	assign pv_in = !parent_bone[8] && (par_ext < CW'(bone_q));

	assign we = (state_q == S_WRITE);
	assign waddr = {bone_q, cnt_q};
	assign raddr = {pidx_q, cnt_q};

	always_comb begin
		xx = AWD'(qp_q[0]);
		yy = AWD'(qp_q[1]);
		zz = AWD'(qp_q[2]);
		xy = AWD'(qp_q[3]);
		xz = AWD'(qp_q[4]);
		yz = AWD'(qp_q[5]);
		wx = AWD'(qp_q[6]);
		wy = AWD'(qp_q[7]);
		wz = AWD'(qp_q[8]);
		one = AWD'(1) <<< sgt_pkg::ROT_BITS;
		case ({r_q, c_q})
			4'b0000: r28 = one - ((yy + zz) <<< 1);
			4'b0001: r28 = (xy - wz) <<< 1;
			4'b0010: r28 = (xz + wy) <<< 1;
			4'b0100: r28 = (xy + wz) <<< 1;
			4'b0101: r28 = one - ((xx + zz) <<< 1);
			4'b0110: r28 = (yz - wx) <<< 1;
			4'b1000: r28 = (xz - wy) <<< 1;
			4'b1001: r28 = (yz + wx) <<< 1;
			4'b1010: r28 = one - ((xx + yy) <<< 1);
			default: r28 = '0;
		endcase
		rf = (r28 + (AWD'(1) <<< (RSH - 1))) >>> RSH;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_QUAT: begin
				case (cnt_q)
					4'd0: begin mul_a = AWD'(q_q[1]); mul_b = 32'(q_q[1]); end
					4'd1: begin mul_a = AWD'(q_q[2]); mul_b = 32'(q_q[2]); end
					4'd2: begin mul_a = AWD'(q_q[3]); mul_b = 32'(q_q[3]); end
					4'd3: begin mul_a = AWD'(q_q[1]); mul_b = 32'(q_q[2]); end
					4'd4: begin mul_a = AWD'(q_q[1]); mul_b = 32'(q_q[3]); end
					4'd5: begin mul_a = AWD'(q_q[2]); mul_b = 32'(q_q[3]); end
					4'd6: begin mul_a = AWD'(q_q[0]); mul_b = 32'(q_q[1]); end
					4'd7: begin mul_a = AWD'(q_q[0]); mul_b = 32'(q_q[2]); end
					4'd8: begin mul_a = AWD'(q_q[0]); mul_b = 32'(q_q[3]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_LOC: begin
				mul_a = rf;
				mul_b = s_q[c_q];
			end
			S_GLOB: begin
				mul_a = AWD'(p_q[r_q][k_q]);
				mul_b = loc_q[k_q][c_q];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		rp = sgt_pkg::round_shift(sgt_pkg::acc_t'(prod_q), FRACTION_BITS);
		sum = acc_q + rp;
		fin = (c_q == 2'd3) ? sum + sgt_pkg::acc_t'(p_q[r_q][3]) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ph_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			bone_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_QUAT;
						cnt_q <= '0;
						ph_q <= 1'b0;
					end
				end
				S_QUAT: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (cnt_q == 4'd8) begin
							state_q <= S_LOC;
							cnt_q <= '0;
							r_q <= '0;
							c_q <= '0;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				S_LOC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (c_q == 2'd2) begin
							c_q <= '0;
							if (r_q == 2'd2) begin
								r_q <= '0;
								cnt_q <= '0;
								state_q <= pv_q ? S_PFETCH : S_WRITE;
							end else begin
								r_q <= r_q + 2'd1;
							end
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				S_PFETCH: begin
					rd_pend_q <= (cnt_q != 4'd12);
					if (cnt_q == 4'd12) begin
						state_q <= S_GLOB;
						cnt_q <= '0;
						r_q <= '0;
						c_q <= '0;
						k_q <= '0;
						ph_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_GLOB: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (k_q == 2'd2) begin
							k_q <= '0;
							if (c_q == 2'd3) begin
								c_q <= '0;
								if (r_q == 2'd2) begin
									r_q <= '0;
									cnt_q <= '0;
									state_q <= S_WRITE;
								end else begin
									r_q <= r_q + 2'd1;
								end
							end else begin
								c_q <= c_q + 2'd1;
							end
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				S_WRITE: begin
					if (cnt_q[3:2] == 2'd2 && cnt_q[1:0] == 2'd3) begin
						state_q <= S_OUT;
						cnt_q <= '0;
						if (last_q || bone_q == BW'(MAX_BONES - 1))
							bone_q <= '0;
						else
							bone_q <= bone_q + BW'(1);
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			s_q[0] <= scale_x;
			s_q[1] <= scale_y;
			s_q[2] <= scale_z;
			q_q[0] <= quat_w;
			q_q[1] <= quat_x;
			q_q[2] <= quat_y;
			q_q[3] <= quat_z;
			pv_q <= pv_in;
			pidx_q <= par_ext[BW-1:0];
			last_q <= last_bone;
			loc_q[0][3] <= translation_x;
			loc_q[1][3] <= translation_y;
			loc_q[2][3] <= translation_z;
			m_q[0][3] <= translation_x;
			m_q[1][3] <= translation_y;
			m_q[2][3] <= translation_z;
		end
		if (state_q == S_QUAT && ph_q)
			qp_q[cnt_q] <= prod_q[31:0];
		if (state_q == S_LOC && ph_q) begin
			loc_q[r_q][c_q] <= sgt_pkg::sat32(rp);
			m_q[r_q][c_q] <= sgt_pkg::sat32(rp);
		end
		if (state_q == S_PFETCH) begin
			rd_idx_q <= cnt_q;
			if (rd_pend_q)
				p_q[rd_idx_q[3:2]][rd_idx_q[1:0]] <= rdata_q;
		end
		if (state_q == S_PFETCH)
			acc_q <= '0;
		else if (state_q == S_GLOB && ph_q) begin
			if (k_q == 2'd2) begin
				acc_q <= '0;
				m_q[r_q][c_q] <= sgt_pkg::sat32(fin);
			end else begin
				acc_q <= sum;
			end
		end
	end

	assign m_row0_col0 = m_q[0][0];
	assign m_row0_col1 = m_q[0][1];
	assign m_row0_col2 = m_q[0][2];
	assign m_row0_col3 = m_q[0][3];
	assign m_row1_col0 = m_q[1][0];
	assign m_row1_col1 = m_q[1][1];
	assign m_row1_col2 = m_q[1][2];
	assign m_row1_col3 = m_q[1][3];
	assign m_row2_col0 = m_q[2][0];
	assign m_row2_col1 = m_q[2][1];
	assign m_row2_col2 = m_q[2][2];
	assign m_row2_col3 = m_q[2][3];

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BONE_LIMIT = sgt_pkg::MAX_BONES_DEF;
	localparam int FRAC = sgt_pkg::FRACTION_BITS_DEF;
	localparam int RANDOM_WORDS = 1950;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic signed [31:0] tr [3];
		logic signed [15:0] qw, qx, qy, qz;
		logic signed [31:0] sc [3];
		logic signed [8:0] parent;
		logic last;
	} bone_t;

	typedef struct {
		logic signed [31:0] m [12];
	} pose_row_t;

	typedef struct {
		bone_t b;
		logic known;
		logic signed [31:0] m [12];
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] translation_x = '0, translation_y = '0, translation_z = '0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
	logic signed [8:0] parent_bone = '0;
	logic last_bone = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] m_row0_col0, m_row0_col1, m_row0_col2, m_row0_col3;
	logic signed [31:0] m_row1_col0, m_row1_col1, m_row1_col2, m_row1_col3;
	logic signed [31:0] m_row2_col0, m_row2_col1, m_row2_col2, m_row2_col3;

	skeleton_global_transform_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [31:0] global_store [BONE_LIMIT][12];
	int unsigned next_position = 0;
	pose_row_t expected_rows [$];
	pose_row_t last_got;
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	bit sending_done = 0;
	table_row_t directed [$];

	function automatic logic signed [69:0] round_down(input logic signed [69:0] v, input int s);
		logic signed [69:0] half;
		half = 70'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [69:0] v);
		logic signed [31:0] r;
		if (v > 70'sh7fffffff)
			r = 32'sh7fffffff;
		else if (v < -70'sh80000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic pose_row_t forward_kinematics(input bone_t b);
		logic signed [69:0] w, x, y, z, one;
		logic signed [69:0] rot [3][3];
		logic signed [31:0] loc [12];
		logic signed [69:0] acc;
		pose_row_t res;
		int p;
		w = b.qw;
		x = b.qx;
		y = b.qy;
		z = b.qz;
		one = 70'sd1 <<< 28;
		rot[0][0] = one - 2 * (y * y + z * z);
		rot[0][1] = 2 * (x * y - w * z);
		rot[0][2] = 2 * (x * z + w * y);
		rot[1][0] = 2 * (x * y + w * z);
		rot[1][1] = one - 2 * (x * x + z * z);
		rot[1][2] = 2 * (y * z - w * x);
		rot[2][0] = 2 * (x * z - w * y);
		rot[2][1] = 2 * (y * z + w * x);
		rot[2][2] = one - 2 * (x * x + y * y);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++)
				loc[r * 4 + c] = clamp32(round_down(
					round_down(rot[r][c], 28 - FRAC) * 70'(b.sc[c]), FRAC));
			loc[r * 4 + 3] = b.tr[r];
		end
		p = b.parent;
		if (p >= 0 && p < next_position) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++) begin
					acc = 0;
					for (int k = 0; k < 3; k++)
						acc += round_down(70'(global_store[p][r * 4 + k]) *
							70'(loc[k * 4 + c]), FRAC);
					if (c == 3)
						acc += 70'(global_store[p][r * 4 + 3]);
					res.m[r * 4 + c] = clamp32(acc);
				end
		end else begin
			res.m = loc;
		end
		if (next_position >= BONE_LIMIT)
			next_position = 0;
		global_store[next_position] = res.m;
		if (b.last)
			next_position = 0;
		else
			next_position = (next_position + 1) % BONE_LIMIT;
		return res;
	endfunction

	function automatic bone_t random_bone(input int kind);
		bone_t b;
		for (int k = 0; k < 3; k++) begin
			b.tr[k] = kind == 0 ? $urandom : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			b.sc[k] = kind == 0 ? $urandom : $signed($urandom_range(0, 1 << 18)) - (1 << 17);
		end
		b.qw = 16'($urandom);
		b.qx = 16'($urandom);
		b.qy = 16'($urandom);
		b.qz = 16'($urandom);
		if (kind != 0) begin
			b.qw = b.qw >>> 2;
			b.qx = b.qx >>> 2;
			b.qy = b.qy >>> 2;
			b.qz = b.qz >>> 2;
		end
		if ($urandom_range(0, 9) == 0)
			b.parent = 9'($urandom);
		else if (next_position == 0 || $urandom_range(0, 7) == 0)
			b.parent = -9'sd1;
		else
			b.parent = 9'($urandom_range(0, next_position - 1));
		b.last = $urandom_range(0, 19) == 0;
		return b;
	endfunction

	function automatic table_row_t row(input bone_t b);
		table_row_t t;
		t.b = b;
		t.known = 1'b0;
		return t;
	endfunction

	function automatic bone_t plain_bone(input logic signed [31:0] tv, input logic signed [8:0] p,
			input logic l);
		bone_t b;
		b.tr = '{tv, -tv, tv};
		b.qw = 16'sd16384;
		b.qx = 16'sd0;
		b.qy = 16'sd0;
		b.qz = 16'sd0;
		b.sc = '{32'sh10000, 32'sh10000, 32'sh10000};
		b.parent = p;
		b.last = l;
		return b;
	endfunction

	task automatic send(input bone_t b);
		translation_x <= b.tr[0];
		translation_y <= b.tr[1];
		translation_z <= b.tr[2];
		quat_w <= b.qw;
		quat_x <= b.qx;
		quat_y <= b.qy;
		quat_z <= b.qz;
		scale_x <= b.sc[0];
		scale_y <= b.sc[1];
		scale_z <= b.sc[2];
		parent_bone <= b.parent;
		last_bone <= b.last;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 30)) @(negedge clk);
	endtask

	always @(posedge clk) begin
		pose_row_t want, got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bone_t b;
				b.tr = '{translation_x, translation_y, translation_z};
				b.qw = quat_w;
				b.qx = quat_x;
				b.qy = quat_y;
				b.qz = quat_z;
				b.sc = '{scale_x, scale_y, scale_z};
				b.parent = parent_bone;
				b.last = last_bone;
				expected_rows.insert(expected_rows.size(), forward_kinematics(b));
			end
			if (out_valid && out_ready) begin
				got.m = '{m_row0_col0, m_row0_col1, m_row0_col2, m_row0_col3,
					m_row1_col0, m_row1_col1, m_row1_col2, m_row1_col3,
					m_row2_col0, m_row2_col1, m_row2_col2, m_row2_col3};
				last_got = got;
				if (expected_rows.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output word at %0t", $realtime);
				end else begin
					want = expected_rows.pop_front();
					for (int k = 0; k < 12; k++)
						if (got.m[k] !== want.m[k]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("entry %0d: expected %0d, got %0d", k,
									want.m[k], got.m[k]);
						end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(sending_done && expected_rows.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT && !timed_out) begin
				timed_out = 1;
				$display("[skeleton_global_transform_core] ERROR");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		int phase;
		phase = int'($realtime / 4);
		if ((phase / 512) % 3 == 2)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0) && (phase % 37 < 30);
	end

	initial begin
		table_row_t t;
		bone_t b;
		int burst;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		t = row(plain_bone(32'sh00010000, -1, 0));
		t.known = 1'b1;
		t.m = '{32'sh10000, 0, 0, 32'sh10000, 0, 32'sh10000, 0, -32'sh10000,
			0, 0, 32'sh10000, 32'sh10000};
		directed.insert(directed.size(), t);
		directed.insert(directed.size(), row(plain_bone(32'sh7fffffff, 0, 0)));
		directed.insert(directed.size(), row(plain_bone(32'sh80000000, 1, 0)));
		directed.insert(directed.size(), row(plain_bone(32'sh12345, 5, 0)));
		directed.insert(directed.size(), row(plain_bone(32'sh100, 255, 0)));
		b = plain_bone(32'sh7fffffff, 2, 0);
		b.sc = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
		directed.insert(directed.size(), row(b));
		b = plain_bone(32'sh7fffffff, 5, 0);
		b.sc = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
		directed.insert(directed.size(), row(b));
		b = plain_bone(0, -256, 0);
		b.qw = 16'sh7fff;
		b.qx = 16'sh8000;
		b.qy = 16'sh7fff;
		b.qz = 16'sh8000;
		directed.insert(directed.size(), row(b));
		b.qw = 16'sh8000;
		b.qx = 16'sh7fff;
		b.qy = 16'sh8000;
		b.qz = 16'sh7fff;
		b.parent = 9'sd7;
		directed.insert(directed.size(), row(b));
		b = plain_bone(32'sh30000, 8, 1);
		b.qw = 16'sd0;
		b.qx = 16'sd11585;
		b.qz = 16'sd11585;
		directed.insert(directed.size(), row(b));
		b = plain_bone(32'sh20000, 0, 0);
		directed.insert(directed.size(), row(b));
		b.parent = 9'sd0;
		b.last = 1'b1;
		directed.insert(directed.size(), row(b));

		foreach (directed[i]) begin
			send(directed[i].b);
			if (directed[i].known) begin
				in_valid <= 1'b0;
				wait (expected_rows.size() == 0);
				for (int k = 0; k < 12; k++)
					if (last_got.m[k] !== directed[i].m[k]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("entry %0d: expected %0d, got %0d", k,
								directed[i].m[k], last_got.m[k]);
					end
				@(negedge clk);
			end
		end
		in_valid <= 1'b0;
		wait (expected_rows.size() == 0);
		@(negedge clk);

		for (int n = 0; n < RANDOM_WORDS; ) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && n < RANDOM_WORDS; j++, n++)
				send(random_bone($urandom_range(0, 3) == 0 ? 0 : 1));
			if (n > 300 && n < 320 || n > 1200 && n < 1215) begin
				in_valid <= 1'b0;
				wait (expected_rows.size() == 0);
				@(negedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				gap();
			end
		end
		in_valid <= 1'b0;
		sending_done = 1;
		wait (expected_rows.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_rows.size() == 0)
			$display("[skeleton_global_transform_core] OK");
		else
			$display("[skeleton_global_transform_core] ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/sgt_pkg.sv
rtl/sgt_mul.sv
rtl/sgt_ram.sv
rtl/skeleton_global_transform_core.sv
tb/testbench.sv
